[rtl/core/rtcbcd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtcbcd_pkg
// shared types, codes and helpers for the rtc bcd time field codec
// ----------------------------------------------------------------------------
package rtcbcd_pkg;

   localparam logic FUNC_DECODE = 1'b0;
   localparam logic FUNC_ENCODE = 1'b1;

   localparam logic [2:0] KIND_SECOND  = 3'd0;
   localparam logic [2:0] KIND_MINUTE  = 3'd1;
   localparam logic [2:0] KIND_HOUR    = 3'd2;
   localparam logic [2:0] KIND_DATE    = 3'd3;
   localparam logic [2:0] KIND_MONTH   = 3'd4;
   localparam logic [2:0] KIND_YEAR    = 3'd5;
   localparam logic [2:0] KIND_WEEKDAY = 3'd6;
   localparam logic [2:0] KIND_UNUSED  = 3'd7;

   localparam logic [7:0] HOUR_MODE_BIT = 8'h80;
   localparam logic [7:0] HOUR_PM_BIT   = 8'h20;
   localparam logic [7:0] HOUR_TEN_BIT  = 8'h10;

   typedef struct packed {
      logic       func;
      logic [2:0] field_kind;
      logic [7:0] value_in;
      logic       twelve_hour_mode;
   } req_type;

   typedef struct packed {
      logic [7:0] value_out;
      logic       accepted;
   } rsp_type;

   // quotient by ten through reciprocal multiply, exact for 8-bit values
   function automatic logic [7:0] quot10(input logic [7:0] v);
      logic [15:0] p;
      p = {8'd0, v} * 16'd205;
      return 8'(p >> 11);
   endfunction

   function automatic logic [3:0] rem10(input logic [7:0] v);
      logic [7:0] q;
      logic [7:0] r;
      q = quot10(v);
      r = v - 8'((q << 3) + (q << 1));
      return r[3:0];
   endfunction

   function automatic logic [7:0] times10(input logic [3:0] t);
      logic [7:0] w;
      w = {4'd0, t};
      return 8'((w << 3) + (w << 1));
   endfunction

endpackage
`default_nettype wire

[rtl/core/rtcbcd_codec.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtcbcd_codec
// combinational decode/encode of one time field between binary and bcd byte
// ----------------------------------------------------------------------------
module rtcbcd_codec
   import rtcbcd_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   logic [7:0] v;
   logic [3:0] ones;
   logic [7:0] q_val;
   logic [3:0] r_val;
   logic [7:0] hour_adj;
   logic [7:0] hour_flags;
   logic [7:0] hour_enc;
   logic [7:0] hour_dec;

   assign v     = req.value_in;
   assign ones  = v[3:0];
   assign q_val = quot10(v);
   assign r_val = rem10(v);

   always_comb begin
      hour_adj   = v;
      hour_flags = 8'h00;
      if (req.twelve_hour_mode) begin
         hour_flags = HOUR_MODE_BIT;
         if (v > 8'd12) begin
            hour_flags = HOUR_MODE_BIT | HOUR_PM_BIT;
            hour_adj   = v - 8'd12;
         end
      end else if (v >= 8'd20) begin
         hour_flags = HOUR_PM_BIT;
         hour_adj   = v - 8'd20;
      end
      hour_enc = hour_flags | {4'd0, rem10(hour_adj)};
      if (hour_adj > 8'd9) begin
         hour_enc = hour_enc | HOUR_TEN_BIT;
      end
   end

   always_comb begin
      hour_dec = {4'd0, ones} + (v[4] ? 8'd10 : 8'd0);
      if (v[5]) begin
         hour_dec = hour_dec + (v[7] ? 8'd12 : 8'd20);
      end
   end

   always_comb begin
      rsp.value_out = 8'h00;
      rsp.accepted  = 1'b0;
      if (req.func == FUNC_DECODE) begin
         rsp.accepted = 1'b1;
         case (req.field_kind)
            KIND_SECOND, KIND_MINUTE: begin
               rsp.value_out = times10({1'b0, v[6:4]}) + {4'd0, ones};
            end
            KIND_HOUR: begin
               rsp.value_out = hour_dec;
            end
            KIND_DATE: begin
               rsp.value_out = times10({2'b0, v[5:4]}) + {4'd0, ones};
            end
            KIND_MONTH: begin
               rsp.value_out = times10({3'b0, v[4]}) + {4'd0, ones};
            end
            KIND_YEAR: begin
               rsp.value_out = times10(v[7:4]) + {4'd0, ones};
            end
            KIND_WEEKDAY: begin
               rsp.value_out = {5'd0, v[2:0]};
            end
            default: begin
               rsp.accepted = 1'b0;
            end
         endcase
      end else begin
         case (req.field_kind)
            KIND_SECOND, KIND_MINUTE: begin
               if (v inside {[8'd0:8'd59]}) begin
                  rsp.value_out = {1'b0, q_val[2:0], r_val};
                  rsp.accepted  = 1'b1;
               end
            end
            KIND_HOUR: begin
               rsp.value_out = hour_enc;
               rsp.accepted  = 1'b1;
            end
            KIND_DATE: begin
               if (v inside {[8'd0:8'd31]}) begin
                  rsp.value_out = {2'b0, q_val[1:0], r_val};
                  rsp.accepted  = 1'b1;
               end
            end
            KIND_MONTH: begin
               if (v inside {[8'd1:8'd12]}) begin
                  rsp.value_out = {3'b0, q_val[0], r_val};
                  rsp.accepted  = 1'b1;
               end
            end
            KIND_YEAR: begin
               if (v inside {[8'd0:8'd99]}) begin
                  rsp.value_out = {q_val[3:0], r_val};
                  rsp.accepted  = 1'b1;
               end
            end
            KIND_WEEKDAY: begin
               if (v inside {[8'd1:8'd7]}) begin
                  rsp.value_out = {5'd0, v[2:0]};
                  rsp.accepted  = 1'b1;
               end
            end
            default: begin
               rsp.accepted = 1'b0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

[rtl/core/rtc_bcd_time_field_codec_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_bcd_time_field_codec_unit
// converts one rtc time field between binary and packed bcd register byte
// ----------------------------------------------------------------------------
// A transaction is taken at every clock edge with start high; busy is always
// low, so one field can be sent in every cycle. The input register captures
// the transaction at the accepting edge and the conversion logic loads the
// result register at the next edge, so the result is on the rsp_ ports for
// exactly one cycle with rsp_valid high, starting when that register loads.
// The receiver cannot stall, so it must capture each result in the cycle
// rsp_valid is high. An encode that is out of range (hour encodes are always
// accepted), and any unused field kind, returns value 0 with accepted low,
// meaning no register write should happen.
module rtc_bcd_time_field_codec_unit
   import rtcbcd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_func,
   input  wire logic [2:0] req_field_kind,
   input  wire logic [7:0] req_value_in,
   input  wire logic       req_twelve_hour_mode,
   output logic            rsp_valid,
   output logic [7:0]      rsp_value_out,
   output logic            rsp_accepted
);

   logic    req_vld_ff;
   logic    req_vld_in;
   req_type req_ff;
   req_type req_in;
   logic    rsp_vld_ff;
   logic    rsp_vld_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   assign busy = 1'b0;

   assign req_vld_in = start & ~busy;
   assign req_in     = '{func:             req_func,
                         field_kind:       req_field_kind,
                         value_in:         req_value_in,
                         twelve_hour_mode: req_twelve_hour_mode};

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   rtcbcd_codec u_codec (
      .req (req_ff),
      .rsp (rsp_in)
   );

   assign rsp_vld_in    = req_vld_ff;
   assign rsp_valid     = rsp_vld_ff;
   assign rsp_value_out = rsp_ff.value_out;
   assign rsp_accepted  = rsp_ff.accepted;

endmodule
`default_nettype wire

[verif/tb_rtc_bcd_time_field_codec_unit.sv]
// ----------------------------------------------------------------------------
// tb_rtc_bcd_time_field_codec_unit
// self-checking bench for the rtc bcd time field codec
// ----------------------------------------------------------------------------
// A short table of fixed fields (masking, hour modes, range limits, the unused
// field kind) is sent first. Then random fields follow in phases with
// different sender idle rates. Each transaction taken queues its expected
// result, from the table or a local model. Each result strobe is compared
// field by field with the oldest entry. A watchdog ends a run with no progress.
// ----------------------------------------------------------------------------
module tb_rtc_bcd_time_field_codec_unit
   import rtcbcd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic       func;
      logic [2:0] kind;
      logic [7:0] value;
      logic       h12;
      logic       typed;
      logic [7:0] exp_value;
      logic       exp_acc;
   } field_case_type;

   localparam field_case_type DIRECTED [26] = '{
      '{FUNC_DECODE, KIND_SECOND,  8'h00, 1'b0, 1'b1, 8'd0,  1'b1},
      '{FUNC_DECODE, KIND_SECOND,  8'hFF, 1'b0, 1'b0, 8'd0,  1'b0},
      '{FUNC_DECODE, KIND_MINUTE,  8'h59, 1'b1, 1'b1, 8'd59, 1'b1},
      '{FUNC_DECODE, KIND_HOUR,    8'hB2, 1'b0, 1'b0, 8'd0,  1'b0},
      '{FUNC_DECODE, KIND_HOUR,    8'h23, 1'b0, 1'b1, 8'd23, 1'b1},
      '{FUNC_DECODE, KIND_HOUR,    8'hFF, 1'b0, 1'b0, 8'd0,  1'b0},
      '{FUNC_DECODE, KIND_DATE,    8'hFF, 1'b0, 1'b0, 8'd0,  1'b0},
      '{FUNC_DECODE, KIND_MONTH,   8'hFF, 1'b0, 1'b0, 8'd0,  1'b0},
      '{FUNC_DECODE, KIND_YEAR,    8'h99, 1'b0, 1'b1, 8'd99, 1'b1},
      '{FUNC_DECODE, KIND_YEAR,    8'hFF, 1'b0, 1'b0, 8'd0,  1'b0},
      '{FUNC_DECODE, KIND_WEEKDAY, 8'hFF, 1'b0, 1'b1, 8'd7,  1'b1},
      '{FUNC_DECODE, KIND_UNUSED,  8'h55, 1'b0, 1'b1, 8'd0,  1'b0},
      '{FUNC_ENCODE, KIND_SECOND,  8'd59, 1'b0, 1'b1, 8'h59, 1'b1},
      '{FUNC_ENCODE, KIND_MINUTE,  8'd60, 1'b0, 1'b1, 8'h00, 1'b0},
      '{FUNC_ENCODE, KIND_HOUR,    8'd0,  1'b1, 1'b1, 8'h80, 1'b1},
      '{FUNC_ENCODE, KIND_HOUR,    8'd12, 1'b1, 1'b1, 8'h92, 1'b1},
      '{FUNC_ENCODE, KIND_HOUR,    8'd13, 1'b1, 1'b0, 8'd0,  1'b0},
      '{FUNC_ENCODE, KIND_HOUR,    8'd23, 1'b0, 1'b1, 8'h23, 1'b1},
      '{FUNC_ENCODE, KIND_HOUR,    8'hFF, 1'b1, 1'b0, 8'd0,  1'b0},
      '{FUNC_ENCODE, KIND_DATE,    8'd32, 1'b0, 1'b1, 8'h00, 1'b0},
      '{FUNC_ENCODE, KIND_MONTH,   8'd0,  1'b0, 1'b1, 8'h00, 1'b0},
      '{FUNC_ENCODE, KIND_MONTH,   8'd12, 1'b0, 1'b1, 8'h12, 1'b1},
      '{FUNC_ENCODE, KIND_YEAR,    8'd100, 1'b0, 1'b1, 8'h00, 1'b0},
      '{FUNC_ENCODE, KIND_WEEKDAY, 8'd7,  1'b0, 1'b1, 8'h07, 1'b1},
      '{FUNC_ENCODE, KIND_WEEKDAY, 8'd8,  1'b0, 1'b1, 8'h00, 1'b0},
      '{FUNC_ENCODE, KIND_UNUSED,  8'hFF, 1'b1, 1'b1, 8'h00, 1'b0}
   };

   logic       clock                = 1'b0;
   logic       reset                = 1'b1;
   logic       start                = 1'b0;
   logic       busy;
   logic       req_func             = 1'b0;
   logic [2:0] req_field_kind       = 3'd0;
   logic [7:0] req_value_in         = 8'd0;
   logic       req_twelve_hour_mode = 1'b0;
   logic       rsp_valid;
   logic [7:0] rsp_value_out;
   logic       rsp_accepted;

   logic       drv_typed     = 1'b0;
   logic [7:0] drv_exp_value = 8'd0;
   logic       drv_exp_acc   = 1'b0;

   rsp_type expected_fields [$];
   rsp_type oldest_field;
   int      mismatch_count = 0;
   int      stall_cycles   = 0;
   bit      progress;

   rtc_bcd_time_field_codec_unit dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_func             (req_func),
      .req_field_kind       (req_field_kind),
      .req_value_in         (req_value_in),
      .req_twelve_hour_mode (req_twelve_hour_mode),
      .rsp_valid            (rsp_valid),
      .rsp_value_out        (rsp_value_out),
      .rsp_accepted         (rsp_accepted)
   );

   always #5 clock = ~clock;

   function automatic rsp_type convert_field(logic func, logic [2:0] kind, logic [7:0] v,
                                             logic h12);
      rsp_type     r;
      int unsigned h;
      r.value_out = 8'd0;
      r.accepted  = 1'b0;
      if (func == FUNC_DECODE) begin
         r.accepted = 1'b1;
         case (kind)
            KIND_SECOND, KIND_MINUTE: r.value_out = 8'(v[6:4] * 10 + v[3:0]);
            KIND_HOUR: begin
               if (v[7])
                  r.value_out = 8'(v[5] * 12 + v[4] * 10 + v[3:0]);
               else
                  r.value_out = 8'(v[5] * 20 + v[4] * 10 + v[3:0]);
            end
            KIND_DATE:    r.value_out = 8'(v[5:4] * 10 + v[3:0]);
            KIND_MONTH:   r.value_out = 8'(v[4] * 10 + v[3:0]);
            KIND_YEAR:    r.value_out = 8'(v[7:4] * 10 + v[3:0]);
            KIND_WEEKDAY: r.value_out = {5'd0, v[2:0]};
            default:      r.accepted  = 1'b0;
         endcase
      end else begin
         case (kind)
            KIND_SECOND, KIND_MINUTE: r.accepted = (v <= 8'd59);
            KIND_HOUR:    r.accepted = 1'b1;
            KIND_DATE:    r.accepted = (v <= 8'd31);
            KIND_MONTH:   r.accepted = (v >= 8'd1 && v <= 8'd12);
            KIND_YEAR:    r.accepted = (v <= 8'd99);
            KIND_WEEKDAY: r.accepted = (v >= 8'd1 && v <= 8'd7);
            default:      r.accepted = 1'b0;
         endcase
         if (r.accepted) begin
            if (kind == KIND_HOUR) begin
               h = {24'd0, v};
               if (h12) begin
                  r.value_out = HOUR_MODE_BIT;
                  if (h > 12) begin
                     r.value_out = r.value_out | HOUR_PM_BIT;
                     h = h - 12;
                  end
               end else if (h >= 20) begin
                  r.value_out = HOUR_PM_BIT;
                  h = h - 20;
               end
               if (h > 9)
                  r.value_out = r.value_out | HOUR_TEN_BIT;
               r.value_out = r.value_out | 8'(h % 10);
            end else if (kind == KIND_WEEKDAY) begin
               r.value_out = v & 8'h07;
            end else begin
               r.value_out = {4'(v / 10), 4'(v % 10)};
            end
         end
      end
      return r;
   endfunction

   function automatic field_case_type random_field();
      field_case_type c;
      c           = '0;
      c.func      = 1'($urandom_range(0, 1));
      c.kind      = ($urandom_range(0, 9) == 0) ? KIND_UNUSED : 3'($urandom_range(0, 6));
      c.h12       = 1'($urandom_range(0, 1));
      c.value     = 8'($urandom_range(0, 255));
      if (c.func == FUNC_ENCODE && $urandom_range(0, 3) != 0) begin
         case (c.kind)
            KIND_SECOND, KIND_MINUTE: c.value = 8'($urandom_range(0, 59));
            KIND_HOUR:    c.value = 8'($urandom_range(0, 23));
            KIND_DATE:    c.value = 8'($urandom_range(0, 31));
            KIND_MONTH:   c.value = 8'($urandom_range(1, 12));
            KIND_YEAR:    c.value = 8'($urandom_range(0, 99));
            KIND_WEEKDAY: c.value = 8'($urandom_range(1, 7));
            default:      c.value = 8'($urandom_range(0, 255));
         endcase
      end
      return c;
   endfunction

   task automatic report_mismatch(string what, int got, int exp);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, exp);
      mismatch_count++;
   endtask

   task automatic send_field(field_case_type c);
      start                <= 1'b1;
      req_func             <= c.func;
      req_field_kind       <= c.kind;
      req_value_in         <= c.value;
      req_twelve_hour_mode <= c.h12;
      drv_typed            <= c.typed;
      drv_exp_value        <= c.exp_value;
      drv_exp_acc          <= c.exp_acc;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_cycle();
      start <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (expected_fields.size() != 0) @(negedge clock);
   endtask

   // result check first, then queue the transaction taken at this edge
   always @(posedge clock) begin
      progress = 1'b0;
      if (!reset && rsp_valid) begin
         progress = 1'b1;
         if (expected_fields.size() == 0) begin
            report_mismatch("unexpected result value_out", int'(rsp_value_out), -1);
         end else begin
            oldest_field = expected_fields.pop_front();
            if (rsp_value_out !== oldest_field.value_out)
               report_mismatch("value_out", int'(rsp_value_out),
                               int'(oldest_field.value_out));
            if (rsp_accepted !== oldest_field.accepted)
               report_mismatch("accepted", int'(rsp_accepted),
                               int'(oldest_field.accepted));
         end
      end
      if (!reset && start && !busy) begin
         progress = 1'b1;
         if (drv_typed)
            expected_fields.push_back('{value_out: drv_exp_value, accepted: drv_exp_acc});
         else
            expected_fields.push_back(convert_field(req_func, req_field_kind, req_value_in,
                                                    req_twelve_hour_mode));
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int idle_pct [4];
      int phase_items [4];
      idle_pct    = '{0, 82, 26, 0};
      phase_items = '{500, 300, 500, 400};
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) send_field(DIRECTED[i]);
      drain_results();

      for (int p = 0; p < 4; p++) begin
         for (int n = 0; n < phase_items[p]; n++) begin
            while ($urandom_range(0, 99) < idle_pct[p]) idle_cycle();
            send_field(random_field());
         end
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
